>>> design/mri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLP inference package
// Shared widths, reset values, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mri_pkg;

  localparam int unsigned N_IN_DEF     = 64;
  localparam int unsigned N_HIDDEN_DEF = 32;
  localparam int unsigned N_OUT_DEF    = 10;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned ROW_W     = 8;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned CLS_W     = 4;
  localparam int unsigned LOGIT_W   = 32;
  localparam int unsigned HID_W     = 15;
  localparam int unsigned FRAC_W    = 12;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned PROD_W    = 2 * VAL_W;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_CNT_W  = 11;
  localparam int unsigned HID_CNT_W = 9;
  localparam int unsigned OUT_CNT_W = 5;

  localparam logic [IN_CNT_W-1:0]  IN_COUNT_RST     = 11'd64;
  localparam logic [HID_CNT_W-1:0] HIDDEN_COUNT_RST = 9'd32;
  localparam logic [OUT_CNT_W-1:0] OUT_COUNT_RST    = 5'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_W1   = 3'd0,
    CMD_W2   = 3'd1,
    CMD_HB   = 3'd2,
    CMD_OB   = 3'd3,
    CMD_FEAT = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_COUNT     = 2'd0,
    CFG_HIDDEN_COUNT = 2'd1,
    CFG_OUT_COUNT    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_L1     = 3'd1,
    ST_DRAIN1 = 3'd2,
    ST_L2     = 3'd3,
    ST_DRAIN2 = 3'd4
  } state_e;

  typedef struct packed {
    logic             load;
    logic             issue;
    logic             layer2;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             first;
    logic             last;
    logic             eval_end;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

  typedef struct packed {
    logic             valid;
    logic             layer2;
    logic [ROW_W-1:0] row;
    logic             first;
    logic             last;
    logic             eval_end;
  } mac_tag_t;

endpackage

>>> design/mri_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLP inference controller
// Holds the count registers, accepts commands and sequences both layers.
// ----------------------------------------------------------------------------
module mri_ctrl #(
  parameter int unsigned N_IN     = mri_pkg::N_IN_DEF,
  parameter int unsigned N_HIDDEN = mri_pkg::N_HIDDEN_DEF,
  parameter int unsigned N_OUT    = mri_pkg::N_OUT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mri_pkg::CMD_W-1:0]       cmd_i,
  input  logic [mri_pkg::COL_W-1:0]       col_index_i,
  input  logic                            cfg_we_i,
  input  logic [mri_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mri_pkg::CFG_W-1:0]       cfg_data_i,
  input  mri_pkg::dp_status_t             status_i,
  output mri_pkg::dp_cmd_t                cmd_o,
  output logic                            busy_o
);

  mri_pkg::state_e state_q, state_d;
  logic [mri_pkg::ROW_W-1:0]     row_q, row_d;
  logic [mri_pkg::COL_W-1:0]     col_q, col_d;
  logic [mri_pkg::IN_CNT_W-1:0]  in_count_q;
  logic [mri_pkg::HID_CNT_W-1:0] hidden_count_q;
  logic [mri_pkg::OUT_CNT_W-1:0] out_count_q;

  logic [mri_pkg::IN_CNT_W-1:0]  ni;
  logic [mri_pkg::HID_CNT_W-1:0] nh;
  logic [mri_pkg::OUT_CNT_W-1:0] no;
  logic [mri_pkg::COL_W-1:0]     col_lim;
  logic [mri_pkg::ROW_W-1:0]     row_lim;
  logic                          layer2;
  logic                          col_end;
  logic                          row_end;
  logic                          accept;
  logic                          eval_go;
  logic                          issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q     <= mri_pkg::IN_COUNT_RST;
      hidden_count_q <= mri_pkg::HIDDEN_COUNT_RST;
      out_count_q    <= mri_pkg::OUT_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mri_pkg::CFG_IN_COUNT:     in_count_q     <= cfg_data_i[mri_pkg::IN_CNT_W-1:0];
        mri_pkg::CFG_HIDDEN_COUNT: hidden_count_q <= cfg_data_i[mri_pkg::HID_CNT_W-1:0];
        mri_pkg::CFG_OUT_COUNT:    out_count_q    <= cfg_data_i[mri_pkg::OUT_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (in_count_q == '0) begin
      ni = mri_pkg::IN_CNT_W'(1);
    end else if (in_count_q > mri_pkg::IN_CNT_W'(N_IN)) begin
      ni = mri_pkg::IN_CNT_W'(N_IN);
    end else begin
      ni = in_count_q;
    end
    priority if (hidden_count_q == '0) begin
      nh = mri_pkg::HID_CNT_W'(1);
    end else if (hidden_count_q > mri_pkg::HID_CNT_W'(N_HIDDEN)) begin
      nh = mri_pkg::HID_CNT_W'(N_HIDDEN);
    end else begin
      nh = hidden_count_q;
    end
    priority if (out_count_q == '0) begin
      no = mri_pkg::OUT_CNT_W'(1);
    end else if (out_count_q > mri_pkg::OUT_CNT_W'(N_OUT)) begin
      no = mri_pkg::OUT_CNT_W'(N_OUT);
    end else begin
      no = out_count_q;
    end
  end

  assign layer2  = (state_q == mri_pkg::ST_L2);
  assign col_lim = layer2 ? mri_pkg::COL_W'(nh - 1'b1) : mri_pkg::COL_W'(ni - 1'b1);
  assign row_lim = layer2 ? mri_pkg::ROW_W'(no - 1'b1) : mri_pkg::ROW_W'(nh - 1'b1);
  assign col_end = (col_q == col_lim);
  assign row_end = (row_q == row_lim);
  assign accept  = start_i && (state_q == mri_pkg::ST_IDLE);
  assign eval_go = accept && (cmd_i == mri_pkg::CMD_FEAT) &&
                   (col_index_i == mri_pkg::COL_W'(ni - 1'b1));

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    issue   = 1'b0;
    unique case (state_q)
      mri_pkg::ST_IDLE: begin
        if (eval_go) begin
          state_d = mri_pkg::ST_L1;
          row_d   = '0;
          col_d   = '0;
        end
      end
      mri_pkg::ST_L1: begin
        issue = 1'b1;
        if (col_end) begin
          col_d = '0;
          if (row_end) begin
            state_d = mri_pkg::ST_DRAIN1;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      mri_pkg::ST_DRAIN1: begin
        if (!status_i.pipe_busy) begin
          state_d = mri_pkg::ST_L2;
          row_d   = '0;
          col_d   = '0;
        end
      end
      mri_pkg::ST_L2: begin
        issue = 1'b1;
        if (col_end) begin
          col_d = '0;
          if (row_end) begin
            state_d = mri_pkg::ST_DRAIN2;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      mri_pkg::ST_DRAIN2: begin
        if (!status_i.pipe_busy) begin
          state_d = mri_pkg::ST_IDLE;
        end
      end
      default: state_d = mri_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mri_pkg::ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  assign cmd_o.load     = accept;
  assign cmd_o.issue    = issue;
  assign cmd_o.layer2   = layer2;
  assign cmd_o.row      = row_q;
  assign cmd_o.col      = col_q;
  assign cmd_o.first    = (col_q == '0);
  assign cmd_o.last     = col_end;
  assign cmd_o.eval_end = layer2 && col_end && row_end;
  assign busy_o         = (state_q != mri_pkg::ST_IDLE);

endmodule

>>> design/mri_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLP inference datapath
// Weight, bias, feature and hidden stores; one pipelined multiply-accumulate
// unit; ReLU, logit saturation, argmax and the result register.
// ----------------------------------------------------------------------------
module mri_datapath #(
  parameter int unsigned N_IN     = mri_pkg::N_IN_DEF,
  parameter int unsigned N_HIDDEN = mri_pkg::N_HIDDEN_DEF,
  parameter int unsigned N_OUT    = mri_pkg::N_OUT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mri_pkg::dp_cmd_t                   ctrl_i,
  output mri_pkg::dp_status_t                status_o,
  input  logic [mri_pkg::CMD_W-1:0]          cmd_i,
  input  logic [mri_pkg::ROW_W-1:0]          row_index_i,
  input  logic [mri_pkg::COL_W-1:0]          col_index_i,
  input  logic signed [mri_pkg::VAL_W-1:0]   value_i,
  output logic                               result_valid_o,
  output logic [mri_pkg::CLS_W-1:0]          class_index_o,
  output logic signed [mri_pkg::LOGIT_W-1:0] logit_o,
  output logic                               is_last_o,
  output logic [mri_pkg::CLS_W-1:0]          predicted_class_o
);

  localparam int unsigned W1_DEPTH = N_HIDDEN * N_IN;
  localparam int unsigned W2_DEPTH = N_OUT * N_HIDDEN;
  localparam int unsigned W1_AW    = (W1_DEPTH > 1) ? $clog2(W1_DEPTH) : 1;
  localparam int unsigned W2_AW    = (W2_DEPTH > 1) ? $clog2(W2_DEPTH) : 1;
  localparam int unsigned IN_AW    = (N_IN > 1) ? $clog2(N_IN) : 1;
  localparam int unsigned HID_AW   = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;
  localparam int unsigned OUT_AW   = (N_OUT > 1) ? $clog2(N_OUT) : 1;
  localparam logic [mri_pkg::ROW_W:0] HID_LIM = (mri_pkg::ROW_W + 1)'(N_HIDDEN);
  localparam logic [mri_pkg::ROW_W:0] OUT_LIM = (mri_pkg::ROW_W + 1)'(N_OUT);
  localparam logic [mri_pkg::COL_W:0] IN_LIM  = (mri_pkg::COL_W + 1)'(N_IN);
  localparam logic [mri_pkg::COL_W:0] HC_LIM  = (mri_pkg::COL_W + 1)'(N_HIDDEN);

  logic signed [mri_pkg::VAL_W-1:0] w1_mem [W1_DEPTH];
  logic signed [mri_pkg::VAL_W-1:0] w2_mem [W2_DEPTH];
  logic signed [mri_pkg::VAL_W-1:0] feat_mem [N_IN];
  logic [mri_pkg::HID_W-1:0]        hid_mem [N_HIDDEN];
  logic signed [mri_pkg::VAL_W-1:0] hb_q [N_HIDDEN];
  logic signed [mri_pkg::VAL_W-1:0] ob_q [N_OUT];

  logic ld_w1, ld_w2, ld_hb, ld_ob, ld_feat;
  logic [W1_AW-1:0] w1_waddr, w1_raddr;
  logic [W2_AW-1:0] w2_waddr, w2_raddr;

  logic signed [mri_pkg::VAL_W-1:0] w1_rd_q, w2_rd_q, feat_rd_q;
  logic [mri_pkg::HID_W-1:0]        hid_rd_q;
  mri_pkg::mac_tag_t                s1_q, s2_q, s3_q, s1_d;

  logic signed [mri_pkg::VAL_W-1:0]  op_a, op_b;
  logic signed [mri_pkg::PROD_W-1:0] prod_q;
  logic signed [mri_pkg::VAL_W-1:0]  bias;
  logic signed [mri_pkg::ACC_W-1:0]  bias_acc, prod_ext, acc_q, acc_d;
  logic signed [mri_pkg::ACC_W-1:0]  acc_shr;
  logic [mri_pkg::HID_W-1:0]         relu_val;
  logic signed [mri_pkg::LOGIT_W-1:0] z;
  logic [mri_pkg::CLS_W-1:0]         cls;
  logic                              take_best;
  logic [mri_pkg::CLS_W-1:0]         new_best;
  logic [mri_pkg::CLS_W-1:0]         best_q;
  logic signed [mri_pkg::LOGIT_W-1:0] best_z_q;
  logic                              hid_we;
  logic                              res_fire;

  logic                              res_valid_q, is_last_q;
  logic [mri_pkg::CLS_W-1:0]         class_q, pred_q;
  logic signed [mri_pkg::LOGIT_W-1:0] logit_q;

  assign ld_w1   = ctrl_i.load && (cmd_i == mri_pkg::CMD_W1) &&
                   ({1'b0, row_index_i} < HID_LIM) && ({1'b0, col_index_i} < IN_LIM);
  assign ld_w2   = ctrl_i.load && (cmd_i == mri_pkg::CMD_W2) &&
                   ({1'b0, row_index_i} < OUT_LIM) && ({1'b0, col_index_i} < HC_LIM);
  assign ld_hb   = ctrl_i.load && (cmd_i == mri_pkg::CMD_HB) && ({1'b0, row_index_i} < HID_LIM);
  assign ld_ob   = ctrl_i.load && (cmd_i == mri_pkg::CMD_OB) && ({1'b0, row_index_i} < OUT_LIM);
  assign ld_feat = ctrl_i.load && (cmd_i == mri_pkg::CMD_FEAT) && ({1'b0, col_index_i} < IN_LIM);

  assign w1_waddr = W1_AW'(row_index_i * N_IN + col_index_i);
  assign w2_waddr = W2_AW'(row_index_i * N_HIDDEN + col_index_i);
  assign w1_raddr = W1_AW'(ctrl_i.row * N_IN + ctrl_i.col);
  assign w2_raddr = W2_AW'(ctrl_i.row * N_HIDDEN + ctrl_i.col);

  always_ff @(posedge clk_i) begin
    if (ld_w1) begin
      w1_mem[w1_waddr] <= value_i;
    end
    w1_rd_q <= w1_mem[w1_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ld_w2) begin
      w2_mem[w2_waddr] <= value_i;
    end
    w2_rd_q <= w2_mem[w2_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ld_feat) begin
      feat_mem[col_index_i[IN_AW-1:0]] <= value_i;
    end
    feat_rd_q <= feat_mem[ctrl_i.col[IN_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (hid_we) begin
      hid_mem[s3_q.row[HID_AW-1:0]] <= relu_val;
    end
    hid_rd_q <= hid_mem[ctrl_i.col[HID_AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_HIDDEN; i++) begin
        hb_q[i] <= '0;
      end
    end else if (ld_hb) begin
      hb_q[row_index_i[HID_AW-1:0]] <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_OUT; i++) begin
        ob_q[i] <= '0;
      end
    end else if (ld_ob) begin
      ob_q[row_index_i[OUT_AW-1:0]] <= value_i;
    end
  end

  assign s1_d.valid    = ctrl_i.issue;
  assign s1_d.layer2   = ctrl_i.layer2;
  assign s1_d.row      = ctrl_i.row;
  assign s1_d.first    = ctrl_i.first;
  assign s1_d.last     = ctrl_i.last;
  assign s1_d.eval_end = ctrl_i.eval_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  assign op_a = s1_q.layer2 ? w2_rd_q : w1_rd_q;
  assign op_b = s1_q.layer2 ? $signed({1'b0, hid_rd_q}) : feat_rd_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
  end

  assign bias     = s2_q.layer2 ? ob_q[s2_q.row[OUT_AW-1:0]] : hb_q[s2_q.row[HID_AW-1:0]];
  assign bias_acc = {{(mri_pkg::ACC_W - mri_pkg::VAL_W - mri_pkg::FRAC_W){bias[mri_pkg::VAL_W-1]}},
                     bias, {mri_pkg::FRAC_W{1'b0}}};
  assign prod_ext = {{(mri_pkg::ACC_W - mri_pkg::PROD_W){prod_q[mri_pkg::PROD_W-1]}}, prod_q};
  assign acc_d    = (s2_q.first ? bias_acc : acc_q) + prod_ext;

  always_ff @(posedge clk_i) begin
    if (s2_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign acc_shr = acc_q >>> mri_pkg::FRAC_W;

  always_comb begin
    priority if (acc_q[mri_pkg::ACC_W-1] || (acc_q == '0)) begin
      relu_val = '0;
    end else if (|acc_shr[mri_pkg::ACC_W-1:mri_pkg::HID_W]) begin
      relu_val = '1;
    end else begin
      relu_val = acc_shr[mri_pkg::HID_W-1:0];
    end
  end

  always_comb begin
    priority if ((acc_shr[mri_pkg::ACC_W-1:mri_pkg::LOGIT_W-1] == '0) ||
                 (acc_shr[mri_pkg::ACC_W-1:mri_pkg::LOGIT_W-1] == '1)) begin
      z = acc_shr[mri_pkg::LOGIT_W-1:0];
    end else if (acc_shr[mri_pkg::ACC_W-1]) begin
      z = {1'b1, {(mri_pkg::LOGIT_W - 1){1'b0}}};
    end else begin
      z = {1'b0, {(mri_pkg::LOGIT_W - 1){1'b1}}};
    end
  end

  assign hid_we    = s3_q.valid && s3_q.last && !s3_q.layer2;
  assign res_fire  = s3_q.valid && s3_q.last && s3_q.layer2;
  assign cls       = s3_q.row[mri_pkg::CLS_W-1:0];
  assign take_best = (cls == '0) || (z > best_z_q);
  assign new_best  = take_best ? cls : best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      is_last_q   <= 1'b0;
      pred_q      <= '0;
    end else begin
      res_valid_q <= res_fire;
      is_last_q   <= res_fire && s3_q.eval_end;
      pred_q      <= (res_fire && s3_q.eval_end) ? new_best : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      class_q  <= cls;
      logit_q  <= z;
      best_q   <= new_best;
      best_z_q <= take_best ? z : best_z_q;
    end
  end

  assign status_o.pipe_busy = s1_q.valid || s2_q.valid || s3_q.valid;
  assign result_valid_o     = res_valid_q;
  assign class_index_o      = class_q;
  assign logit_o            = logit_q;
  assign is_last_o          = is_last_q;
  assign predicted_class_o  = pred_q;

endmodule

>>> design/mlp_relu_inference_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLP ReLU inference unit
// Two-layer perceptron with ReLU hidden layer and argmax over the logits.
// ----------------------------------------------------------------------------
// Weight, bias and feature loads keep busy_o low. The feature transfer at
// index ni-1 (ni is the input count clamped to 1..N_IN) starts an evaluation;
// busy_o then stays high while the single multiply-accumulate unit, which
// takes one product per cycle, works through both layers, with a pipeline
// drain after each layer. One result per class is strobed on result_valid_o,
// the last one while busy_o is still high; results cannot be held off. The
// user must write counts only while busy_o is low; the block itself does not
// enforce this.
module mlp_relu_inference_unit #(
  parameter int unsigned N_IN     = mri_pkg::N_IN_DEF,
  parameter int unsigned N_HIDDEN = mri_pkg::N_HIDDEN_DEF,
  parameter int unsigned N_OUT    = mri_pkg::N_OUT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [mri_pkg::CMD_W-1:0]          cmd_i,
  input  logic [mri_pkg::ROW_W-1:0]          row_index_i,
  input  logic [mri_pkg::COL_W-1:0]          col_index_i,
  input  logic signed [mri_pkg::VAL_W-1:0]   value_i,
  input  logic                               cfg_we_i,
  input  logic [mri_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mri_pkg::CFG_W-1:0]          cfg_data_i,
  output logic                               result_valid_o,
  output logic [mri_pkg::CLS_W-1:0]          class_index_o,
  output logic signed [mri_pkg::LOGIT_W-1:0] logit_o,
  output logic                               is_last_o,
  output logic [mri_pkg::CLS_W-1:0]          predicted_class_o
);

  mri_pkg::dp_cmd_t    dp_cmd;
  mri_pkg::dp_status_t dp_status;

  mri_ctrl #(
    .N_IN     (N_IN),
    .N_HIDDEN (N_HIDDEN),
    .N_OUT    (N_OUT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd_i),
    .col_index_i (col_index_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd),
    .busy_o      (busy)
  );

  mri_datapath #(
    .N_IN     (N_IN),
    .N_HIDDEN (N_HIDDEN),
    .N_OUT    (N_OUT)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (dp_cmd),
    .status_o          (dp_status),
    .cmd_i             (cmd_i),
    .row_index_i       (row_index_i),
    .col_index_i       (col_index_i),
    .value_i           (value_i),
    .result_valid_o    (result_valid_o),
    .class_index_o     (class_index_o),
    .logit_o           (logit_o),
    .is_last_o         (is_last_o),
    .predicted_class_o (predicted_class_o)
  );

`ifndef SYNTH
  a_result_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe outside an evaluation");

  a_last_is_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_last_o |-> result_valid_o)
    else $error("is_last_o without result strobe");

  a_pred_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (predicted_class_o != '0) |-> is_last_o)
    else $error("predicted class on a non-final result");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i != mri_pkg::CMD_FEAT)) |=> !busy)
    else $error("load transfer started an evaluation");
`endif

endmodule
